// ----- rtl/core/i2cm_pkg.sv -----
// shared types and constants for the i2c three byte write master
package i2cm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_BIT_LOW  = 4'd3,
    PH_BIT_HIGH = 4'd4,
    PH_ACK_LOW  = 4'd5,
    PH_ACK_HIGH = 4'd6,
    PH_STOP_A   = 4'd7,
    PH_STOP_B   = 4'd8,
    PH_STOP_C   = 4'd9
  } phase_t;

  // register indexes as decoded from paddr[2]
  localparam logic REG_LONG_WAIT  = 1'b0;
  localparam logic REG_SHORT_WAIT = 1'b1;

  localparam logic [15:0] LONG_WAIT_RST  = 16'd1000;
  localparam logic [15:0] SHORT_WAIT_RST = 16'd500;

  // index of the last byte of a transfer
  localparam logic [1:0] LAST_BYTE = 2'd2;

  typedef struct packed {
    logic [15:0] long_wait;
    logic [15:0] short_wait;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] device_address;
    logic [7:0] command_byte;
    logic [7:0] data_byte;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic sda_drive;
    logic busy_res;
    logic done_res;
    logic nack;
  } result_t;

endpackage

// ----- rtl/core/i2cm_cfg.sv -----
// apb register file for the wait lengths
module i2cm_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output i2cm_pkg::cfg_t      cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_wait  <= i2cm_pkg::LONG_WAIT_RST;
      cfg.short_wait <= i2cm_pkg::SHORT_WAIT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        i2cm_pkg::REG_LONG_WAIT:  cfg.long_wait  <= pwdata[15:0];
        i2cm_pkg::REG_SHORT_WAIT: cfg.short_wait <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      i2cm_pkg::REG_LONG_WAIT:  prdata = {16'd0, cfg.long_wait};
      i2cm_pkg::REG_SHORT_WAIT: prdata = {16'd0, cfg.short_wait};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/core/i2cm_seq.sv -----
// bus sequencer state and one-tick next state logic
module i2cm_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  i2cm_pkg::item_t     item,
  input  i2cm_pkg::cfg_t      cfg,
  output i2cm_pkg::result_t   result
);

  i2cm_pkg::phase_t phase, phase_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] wait_count, wait_count_next;
  logic        nack_seen, nack_seen_next;
  logic [7:0]  held_bytes [3];

  logic             start;
  i2cm_pkg::phase_t ph;
  logic [15:0]      wc;
  logic [7:0]       sb;
  logic [1:0]       bidx_inc;
  logic [7:0]       load_val;
  logic             bit_val;

  assign start = (phase == i2cm_pkg::PH_IDLE) & item.kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2cm_pkg::PH_IDLE;
      byte_index <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      wait_count <= '0;
      nack_seen  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      wait_count <= wait_count_next;
      nack_seen  <= nack_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && start) begin
      held_bytes[0] <= item.device_address;
      held_bytes[1] <= item.command_byte;
      held_bytes[2] <= item.data_byte;
    end
  end

  always_comb begin
    bidx_inc = byte_index + 2'd1;
    case (bidx_inc)
      2'd0:    load_val = held_bytes[0];
      2'd1:    load_val = held_bytes[1];
      2'd2:    load_val = held_bytes[2];
      default: load_val = 8'd0;
    endcase

    phase_next      = phase;
    byte_index_next = byte_index;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    nack_seen_next  = nack_seen;
    ph              = phase;
    wc              = wait_count;
    sb              = shift_byte;

    // request tick already counts as the first tick of the start segment
    if (start) begin
      ph              = i2cm_pkg::PH_START_A;
      wc              = cfg.long_wait;
      sb              = item.device_address;
      byte_index_next = '0;
      bit_index_next  = '0;
      nack_seen_next  = 1'b0;
    end
    shift_byte_next = sb;
    bit_val         = sb[7];
    wait_count_next = wc;
    phase_next      = ph;

    result = '{scl_level: 1'b1, sda_level: 1'b1, sda_drive: 1'b1,
               busy_res: 1'b0, done_res: 1'b0, nack: 1'b0};
    case (ph)
      i2cm_pkg::PH_START_B:  result.sda_level = 1'b0;
      i2cm_pkg::PH_BIT_LOW:  begin
        result.scl_level = 1'b0;
        result.sda_level = bit_val;
      end
      i2cm_pkg::PH_BIT_HIGH: result.sda_level = bit_val;
      i2cm_pkg::PH_ACK_LOW:  begin
        result.scl_level = 1'b0;
        result.sda_drive = 1'b0;
      end
      i2cm_pkg::PH_ACK_HIGH: begin
        result.sda_level = 1'b1;
        result.sda_drive = 1'b0;
      end
      i2cm_pkg::PH_STOP_A:   begin
        result.scl_level = 1'b0;
        result.sda_level = 1'b0;
      end
      i2cm_pkg::PH_STOP_B:   result.sda_level = 1'b0;
      default: ;
    endcase

    if (ph != i2cm_pkg::PH_IDLE) begin
      result.busy_res = 1'b1;
      if (wc != 16'd0) begin
        wait_count_next = wc - 16'd1;
      end else begin
        case (ph)
          i2cm_pkg::PH_START_A: begin
            phase_next      = i2cm_pkg::PH_START_B;
            wait_count_next = cfg.short_wait;
          end
          i2cm_pkg::PH_START_B, i2cm_pkg::PH_ACK_LOW: begin
            phase_next      = (ph == i2cm_pkg::PH_START_B) ? i2cm_pkg::PH_BIT_LOW
                                                            : i2cm_pkg::PH_ACK_HIGH;
            wait_count_next = cfg.short_wait;
          end
          i2cm_pkg::PH_BIT_LOW: begin
            phase_next      = i2cm_pkg::PH_BIT_HIGH;
            wait_count_next = cfg.short_wait;
          end
          i2cm_pkg::PH_BIT_HIGH: begin
            shift_byte_next = {sb[6:0], 1'b0};
            bit_index_next  = bit_index + 3'd1;
            wait_count_next = cfg.short_wait;
            phase_next      = (bit_index == 3'd7) ? i2cm_pkg::PH_ACK_LOW
                                                  : i2cm_pkg::PH_BIT_LOW;
          end
          i2cm_pkg::PH_ACK_HIGH: begin
            if (item.sda_sample) begin
              nack_seen_next  = 1'b1;
              phase_next      = i2cm_pkg::PH_STOP_A;
              wait_count_next = cfg.long_wait;
            end else begin
              byte_index_next = bidx_inc;
              if (byte_index == i2cm_pkg::LAST_BYTE) begin
                phase_next      = i2cm_pkg::PH_STOP_A;
                wait_count_next = cfg.long_wait;
              end else begin
                shift_byte_next = load_val;
                bit_index_next  = '0;
                phase_next      = i2cm_pkg::PH_BIT_LOW;
                wait_count_next = cfg.short_wait;
              end
            end
          end
          i2cm_pkg::PH_STOP_A: begin
            phase_next      = i2cm_pkg::PH_STOP_B;
            wait_count_next = cfg.long_wait;
          end
          i2cm_pkg::PH_STOP_B: begin
            phase_next      = i2cm_pkg::PH_STOP_C;
            wait_count_next = cfg.long_wait;
          end
          default: begin
            result.done_res = 1'b1;
            result.nack     = nack_seen;
            phase_next      = i2cm_pkg::PH_IDLE;
            wait_count_next = '0;
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/i2c_master_three_byte_write.sv -----
// top level of the i2c master three byte register write
// Each input transaction is one timing tick of the bus sequencer and produces exactly one
// output transaction carrying the line levels for that tick plus busy/done/nack status.
// A tick with s_tuser (kind) high while idle latches the three bytes and starts a transfer:
// start condition, device address, command byte and data byte sent msb first, each followed
// by an acknowledge clock with sda released, then the stop condition. sda_sample is only
// looked at on the last tick of each acknowledge high half; a 1 there aborts to the stop
// and reports nack with done. Every segment lasts wait+1 ticks, long_wait (reg 0, byte
// address 0) for the first start segment and the three stop segments, short_wait (reg 1, byte
// address 4) for the second start segment and per clock half. Throughput is one tick per clock:
// a tick is held in the input register, the sequencer state updates in one pass of its next
// state logic, the result lands in the output register, and m_tready back pressure stalls both
// stages. Write the wait registers only while no ticks are in flight; paddr[1:0] is ignored.
module i2c_master_three_byte_write (
  input  logic        clk,
  input  logic        rst,
  // input tick stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // device_address, command_byte, data_byte, sda_sample, 7'b0
  input  logic        s_tuser,  // kind
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // scl_level, sda_level, sda_drive, busy_res, done_res, nack, 2'b0
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cm_pkg::cfg_t    cfg;
  i2cm_pkg::item_t   item;
  i2cm_pkg::result_t result;
  logic              in_valid;
  logic              adv;

  // a held tick moves on when the output register is free or being drained
  assign adv      = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.kind           <= s_tuser;
      item.device_address <= s_tdata[7:0];
      item.command_byte   <= s_tdata[15:8];
      item.data_byte      <= s_tdata[23:16];
      item.sda_sample     <= s_tdata[24];
    end
  end

  i2cm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (adv),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {2'b00, result.nack, result.done_res, result.busy_res,
                  result.sda_drive, result.sda_level, result.scl_level};
    end
  end

endmodule
